[rtl/bit_parallel_edit_distance_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bit-parallel edit distance unit
// Clocked property shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BIT_PARALLEL_EDIT_DISTANCE_UNIT_ASSERT_SVH
`define BIT_PARALLEL_EDIT_DISTANCE_UNIT_ASSERT_SVH

// same-cycle implication
`define BPED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BPED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bped_pkg.sv]
// ----------------------------------------------------------------------------
// bped_pkg
// Types and codes shared by the bit-parallel edit distance unit.
// ----------------------------------------------------------------------------
package bped_pkg;

   localparam int KIND_W    = 2;
   localparam int SYMBOL_W  = 21;
   localparam int SCORE_W   = 25;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 25;

   localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TEXT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LATE     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_ENABLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE = 1'b1;

   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   // per-item commands from the control section to the recurrence core
   typedef struct packed {
      logic load;
      logic text;
      logic clear;
   } job_ctrl_type;

endpackage

[rtl/bped_req_if.sv]
// ----------------------------------------------------------------------------
// bped_req_if
// Input item channel: kind and symbol with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bped_req_if;
   logic                           valid;
   logic                           ready;
   logic [bped_pkg::KIND_W-1:0]    kind;
   logic [bped_pkg::SYMBOL_W-1:0]  symbol;

   modport source (output valid, kind, symbol, input ready);
   modport sink   (input valid, kind, symbol, output ready);
endinterface

[rtl/bped_rsp_if.sv]
// ----------------------------------------------------------------------------
// bped_rsp_if
// Result item channel: distance and status with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bped_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bped_pkg::SCORE_W-1:0]   distance;
   logic [bped_pkg::STATUS_W-1:0]  status;

   modport source (output valid, distance, status, input ready);
   modport sink   (input valid, distance, status, output ready);
endinterface

[rtl/bit_parallel_edit_distance_unit.sv]
// ----------------------------------------------------------------------------
// bit_parallel_edit_distance_unit
// Levenshtein distance of a loaded pattern against a streamed text.
//
// Load up to PATTERN_MAX pattern symbols (kind 0), stream the text one symbol
// per item (kind 1), then send an end item (kind 2) to get the distance and a
// status; the job state then clears while the clamp registers keep their
// values. Supply the shorter string as the pattern. The unit accepts one item
// per clock: each item is captured in an input register and processed from
// there, where a text symbol is compared against all stored pattern symbols
// at once and one PATTERN_MAX-bit add updates the delta words. A result is
// formed as its end item leaves the input register and sits in an output
// register; only an end item stalls, and only while the previous result has
// not been taken. Write the csr registers only while no job is in flight.
// ----------------------------------------------------------------------------
module bit_parallel_edit_distance_unit #(
   parameter int PATTERN_MAX = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   bped_req_if.sink                          req_ch,
   bped_rsp_if.source                        rsp_ch,
   input  logic                              csr_write_enable,
   input  logic [bped_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bped_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int SW    = bped_pkg::SCORE_W;

   // input register
   logic                           in_valid_ff, in_valid_in;
   logic [bped_pkg::KIND_W-1:0]    in_kind_ff;
   logic [bped_pkg::SYMBOL_W-1:0]  in_symbol_ff;

   // job state
   logic [LEN_W-1:0]               length_ff, length_in;
   logic                           started_ff, started_in;
   logic [bped_pkg::STATUS_W-1:0]  error_ff, error_in;

   // configuration
   logic                           clamp_ff;
   logic [SW-1:0]                  max_dist_ff;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                  rsp_dist_ff;
   logic [bped_pkg::STATUS_W-1:0]  rsp_status_ff;

   logic                    req_fire, fire;
   logic                    is_load, is_text, is_end, load_ok, full;
   bped_pkg::job_ctrl_type  ctrl;
   logic [PATTERN_MAX-1:0]  eq, top;
   logic [SW-1:0]           score, out_dist;
   logic [SW:0]             clamped;

   // an end item waits while the previous result is still held
   assign fire = in_valid_ff &&
                 ((in_kind_ff != bped_pkg::KIND_END) || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || fire;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign is_load = fire && (in_kind_ff == bped_pkg::KIND_LOAD);
   assign is_text = fire && (in_kind_ff == bped_pkg::KIND_TEXT);
   assign is_end  = fire && (in_kind_ff == bped_pkg::KIND_END);
   assign full    = (length_ff >= LEN_W'(PATTERN_MAX));
   assign load_ok = is_load && !started_ff && !full;

   assign ctrl.load  = load_ok;
   assign ctrl.text  = is_text;
   assign ctrl.clear = is_end;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      length_in  = length_ff;
      started_in = started_ff;
      error_in   = error_ff;
      if (is_end) begin
         length_in  = '0;
         started_in = 1'b0;
         error_in   = bped_pkg::STATUS_OK;
      end else if (is_text) begin
         started_in = 1'b1;
      end else if (is_load) begin
         if (load_ok) begin
            length_in = length_ff + 1'b1;
         end else if (error_ff == bped_pkg::STATUS_OK) begin
            // keep the first error of the job
            error_in = started_ff ? bped_pkg::STATUS_LATE : bped_pkg::STATUS_OVERFLOW;
         end
      end
   end

   // clamp to max + 1, saturating at the field range
   assign clamped = {1'b0, max_dist_ff} + (SW + 1)'(1);
   always_comb begin
      out_dist = score;
      if (clamp_ff && (score > max_dist_ff)) begin
         out_dist = clamped[SW] ? {SW{1'b1}} : clamped[SW-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (is_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         length_ff    <= '0;
         started_ff   <= 1'b0;
         error_ff     <= bped_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
         clamp_ff     <= 1'b0;
         max_dist_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         length_ff    <= length_in;
         started_ff   <= started_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               bped_pkg::CSR_CLAMP_ENABLE: clamp_ff    <= csr_write_data[0];
               bped_pkg::CSR_MAX_DISTANCE: max_dist_ff <= csr_write_data[SW-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff   <= req_ch.kind;
         in_symbol_ff <= req_ch.symbol;
      end
      if (is_end) begin
         rsp_dist_ff   <= out_dist;
         rsp_status_ff <= error_ff;
      end
   end

   bped_match #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_W       (LEN_W),
      .IDX_W       (IDX_W)
   ) u_match (
      .clock      (clock),
      .write_en   (load_ok),
      .write_addr (length_ff[IDX_W-1:0]),
      .symbol     (in_symbol_ff),
      .length     (length_ff),
      .eq         (eq),
      .top        (top)
   );

   bped_core #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .has_pattern (length_ff != '0),
      .eq          (eq),
      .top         (top),
      .score       (score)
   );

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.distance = rsp_dist_ff;
   assign rsp_ch.status   = rsp_status_ff;

endmodule

[rtl/bped_match.sv]
// ----------------------------------------------------------------------------
// bped_match
// Pattern symbol store and parallel compare that forms the match mask.
// ----------------------------------------------------------------------------
module bped_match #(
   parameter int PATTERN_MAX = 64,
   parameter int LEN_W       = $clog2(PATTERN_MAX + 1),
   parameter int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
   input  logic                           clock,
   input  logic                           write_en,
   input  logic [IDX_W-1:0]               write_addr,
   input  logic [bped_pkg::SYMBOL_W-1:0]  symbol,
   input  logic [LEN_W-1:0]               length,
   output logic [PATTERN_MAX-1:0]         eq,
   output logic [PATTERN_MAX-1:0]         top
);

   logic [bped_pkg::SYMBOL_W-1:0] pattern_ff [PATTERN_MAX];

   always_ff @(posedge clock) begin
      if (write_en) begin
         pattern_ff[write_addr] <= symbol;
      end
   end

   // one comparator per lane; lanes at or above the length never match
   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_lane
      assign eq[i]  = (LEN_W'(i) < length) && (pattern_ff[i] == symbol);
      assign top[i] = (LEN_W'(i + 1) == length);
   end

endmodule

[rtl/bped_core.sv]
// ----------------------------------------------------------------------------
// bped_core
// Vertical delta words and score, advanced by one text symbol per cycle while text items arrive.
// ----------------------------------------------------------------------------
module bped_core #(
   parameter int PATTERN_MAX = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bped_pkg::job_ctrl_type        ctrl,
   input  logic                          has_pattern,
   input  logic [PATTERN_MAX-1:0]        eq,
   input  logic [PATTERN_MAX-1:0]        top,
   output logic [bped_pkg::SCORE_W-1:0]  score
);

   logic [PATTERN_MAX-1:0]        vp_ff, vp_in;
   logic [PATTERN_MAX-1:0]        vm_ff, vm_in;
   logic [bped_pkg::SCORE_W-1:0]  score_ff, score_in;

   logic [PATTERN_MAX-1:0] xv, xh, ph, mh, ph_s, mh_s;
   logic                   ph_top, mh_top, score_sat;

   always_comb begin
      xv     = eq | vm_ff;
      xh     = (((eq & vp_ff) + vp_ff) ^ vp_ff) | eq;
      ph     = vm_ff | ~(xh | vp_ff);
      mh     = vp_ff & xh;
      ph_top = |(ph & top);
      mh_top = |(mh & top);
      ph_s   = (ph << 1) | PATTERN_MAX'(1);
      mh_s   = mh << 1;
   end

   assign score_sat = (score_ff == bped_pkg::SCORE_MAX);

   always_comb begin
      vp_in    = vp_ff;
      vm_in    = vm_ff;
      score_in = score_ff;
      if (ctrl.clear) begin
         vp_in    = '1;
         vm_in    = '0;
         score_in = '0;
      end else if (ctrl.load) begin
         if (!score_sat) begin
            score_in = score_ff + 1'b1;
         end
      end else if (ctrl.text) begin
         if (!has_pattern) begin
            if (!score_sat) begin
               score_in = score_ff + 1'b1;
            end
         end else begin
            vp_in = mh_s | ~(xv | ph_s);
            vm_in = ph_s & xv;
            // a saturated score stays put
            if (!score_sat) begin
               if (ph_top) begin
                  score_in = score_ff + 1'b1;
               end else if (mh_top && (score_ff != '0)) begin
                  score_in = score_ff - 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff    <= '1;
         vm_ff    <= '0;
         score_ff <= '0;
      end else begin
         vp_ff    <= vp_in;
         vm_ff    <= vm_in;
         score_ff <= score_in;
      end
   end

   assign score = score_ff;

endmodule

[rtl/bped_checker.sv]
// ----------------------------------------------------------------------------
// bped_checker
// Port-level checks for the edit distance unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "bit_parallel_edit_distance_unit_assert.svh"

module bped_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [bped_pkg::SCORE_W-1:0]   rsp_distance,
   input logic [bped_pkg::STATUS_W-1:0]  rsp_status
);

   `BPED_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   `BPED_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready, "input stalled without a held result")

   `BPED_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status <= bped_pkg::STATUS_LATE, "undefined status code")

   `BPED_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_distance) && $stable(rsp_status), "held result changed")

endmodule

bind bit_parallel_edit_distance_unit bped_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_distance (rsp_ch.distance),
   .rsp_status   (rsp_ch.status)
);
